// ===== src/bhnm_pkg.sv =====
package bhnm_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_ENTRIES = 512;
    localparam int DESC_WORDS  = 4;

    // Descriptor words that the input port carries.
    localparam int IN_DESC_WORDS = 4;

    // Fixed field widths.
    localparam int CMD_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 9;
    localparam int OUT_IDX_W = 9;
    localparam int OUT_DST_W = 9;
    localparam int PT_W     = 32;
    localparam int WORD_W   = 64;
    localparam int WPC_W    = 7;  // popcount of one 64-bit word

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_LIMIT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_CEILING = 2'd1;

    // Register reset values.
    localparam logic [CFG_W-1:0] MATCH_LIMIT_RST    = 9'd80;
    localparam logic [CFG_W-1:0] SEARCH_CEILING_RST = 9'd128;

    // SWAR popcount: three mask/add levels, then eight byte counts summed.
    function automatic logic [WPC_W-1:0] f_popcount64(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WPC_W-1:0]  s;
        a = v - ((v >> 1) & 64'h5555_5555_5555_5555);
        b = (a & 64'h3333_3333_3333_3333) + ((a >> 2) & 64'h3333_3333_3333_3333);
        c = (b + (b >> 4)) & 64'h0F0F_0F0F_0F0F_0F0F;
        s = '0;
        for (int k = 0; k < 8; k++) begin
            s = s + WPC_W'(c[8*k +: 4]);
        end
        return s;
    endfunction

endpackage

// ===== src/brief_hamming_nearest_match.sv =====
// Nearest-match search over a store of binary (BRIEF) descriptors. Each item
// on the input channel is a command: load appends one reference entry (a
// DESC_WORDS x 64-bit descriptor plus four opaque 32-bit point words), clear
// empties the store, query returns the stored entry with the lowest Hamming
// distance to the given descriptor. Only distances strictly below
// search_ceiling are candidates, the earliest entry wins a tie, and a match
// is reported only when the winning distance is strictly below match_limit;
// otherwise found is 0 and every other field is 0. A load into a full store
// is dropped and returns status 1. Code 3 does nothing and returns zeros.
// Every command returns exactly one item. Sequence: a load, clear or code 3
// passes from acceptance to the done state and from there into the output
// register. A query first scans the descriptor memory, one entry per cycle,
// through a three-stage read / popcount / compare pipe; once the pipe has
// drained, the point memory is read at the winner, and the done state then
// loads the output register. Either way the next item is accepted only
// after the output register has been loaded. The block takes one item at a
// time; input stall is high while an item is in flight, and a finished
// result waits in the state machine until the output register is free. The
// stores come up undefined after reset and need no clearing pass; descriptor
// entries at or above the fill count are never read, and their point words
// never reach a result. Configuration writes (index 0 match_limit, index 1
// search_ceiling, other indexes ignored) are always ready and should only be
// issued while the block is idle.
module brief_hamming_nearest_match #(
    parameter int MAX_ENTRIES = bhnm_pkg::MAX_ENTRIES,
    parameter int DESC_WORDS  = bhnm_pkg::DESC_WORDS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    // command channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [bhnm_pkg::CMD_W-1:0]       i_command,
    input  logic [bhnm_pkg::WORD_W-1:0]      i_desc_word0,
    input  logic [bhnm_pkg::WORD_W-1:0]      i_desc_word1,
    input  logic [bhnm_pkg::WORD_W-1:0]      i_desc_word2,
    input  logic [bhnm_pkg::WORD_W-1:0]      i_desc_word3,
    input  logic [bhnm_pkg::PT_W-1:0]        i_pixel_x_bits,
    input  logic [bhnm_pkg::PT_W-1:0]        i_pixel_y_bits,
    input  logic [bhnm_pkg::PT_W-1:0]        i_norm_x_bits,
    input  logic [bhnm_pkg::PT_W-1:0]        i_norm_y_bits,

    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_found,
    output logic [bhnm_pkg::OUT_IDX_W-1:0]   o_best_index,
    output logic [bhnm_pkg::OUT_DST_W-1:0]   o_best_distance,
    output logic [bhnm_pkg::PT_W-1:0]        o_match_pixel_x,
    output logic [bhnm_pkg::PT_W-1:0]        o_match_pixel_y,
    output logic [bhnm_pkg::PT_W-1:0]        o_match_norm_x,
    output logic [bhnm_pkg::PT_W-1:0]        o_match_norm_y,
    output logic                             o_status,

    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [bhnm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bhnm_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int CNT_W   = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int DW      = DESC_WORDS * bhnm_pkg::WORD_W;
    localparam int SUM_W   = $clog2(DW + 1);
    localparam int DIST_W  = (SUM_W > bhnm_pkg::CFG_W) ? SUM_W : bhnm_pkg::CFG_W;
    localparam int PTS_W   = 4 * bhnm_pkg::PT_W;
    localparam int PW      = bhnm_pkg::PT_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    typedef logic [DESC_WORDS-1:0][bhnm_pkg::WORD_W-1:0] t_desc;
    typedef logic [DESC_WORDS-1:0][bhnm_pkg::WPC_W-1:0]  t_wpc;

    // storage
    t_desc              desc_mem [MAX_ENTRIES];
    logic [PTS_W-1:0]   pt_mem   [MAX_ENTRIES];

    // control
    logic [1:0]             r_state;
    logic [CNT_W-1:0]       r_count;
    logic                   r_v1;
    logic                   r_v2;
    logic                   r_out_valid;
    logic [bhnm_pkg::CFG_W-1:0] r_match_limit;
    logic [bhnm_pkg::CFG_W-1:0] r_search_ceiling;

    // datapath
    t_desc                  r_query;
    t_desc                  r_rd_data;
    t_wpc                   r_pc;
    logic [CNT_W-1:0]       r_rd_addr;
    logic [IDX_W-1:0]       r_idx1;
    logic [IDX_W-1:0]       r_idx2;
    logic [DIST_W-1:0]      r_best;
    logic [IDX_W-1:0]       r_best_idx;
    logic                   r_have;
    logic                   r_is_query;
    logic                   r_drop;
    logic [PTS_W-1:0]       r_pt_rd;

    // output register
    logic                             r_found;
    logic [bhnm_pkg::OUT_IDX_W-1:0]   r_best_index;
    logic [bhnm_pkg::OUT_DST_W-1:0]   r_best_distance;
    logic [PTS_W-1:0]                 r_match_pts;
    logic                             r_status;

    t_desc              desc_in;
    logic               in_acc;
    logic               full;
    logic               load_we;
    logic               scan_issue;
    logic               scan_done;
    logic [SUM_W-1:0]   dist_sum;
    logic               better;
    logic               out_free;
    logic               res_move;
    logic               hit;

    // Descriptor words past the fourth read as zero.
    always_comb begin
        for (int w = 0; w < DESC_WORDS; w++) begin
            case (w)
                0:       desc_in[w] = i_desc_word0;
                1:       desc_in[w] = i_desc_word1;
                2:       desc_in[w] = i_desc_word2;
                3:       desc_in[w] = i_desc_word3;
                default: desc_in[w] = '0;
            endcase
        end
    end

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign full       = (r_count == CNT_W'(MAX_ENTRIES));
    assign load_we    = in_acc && (i_command == bhnm_pkg::CMD_LOAD) && !full;
    assign scan_issue = (r_state == S_SCAN) && (r_rd_addr != r_count);
    assign scan_done  = (r_state == S_SCAN) && !scan_issue && !r_v1 && !r_v2;

    // Compare stage: sum word counts, strict less-than keeps the earliest tie.
    always_comb begin
        dist_sum = '0;
        for (int w = 0; w < DESC_WORDS; w++) begin
            dist_sum = dist_sum + SUM_W'(r_pc[w]);
        end
    end
    assign better = r_v2 && (DIST_W'(dist_sum) < r_best);

    assign out_free = !r_out_valid || !i_out_stall;
    assign res_move = (r_state == S_DONE) && out_free;
    assign hit      = r_is_query && r_have && (r_best < DIST_W'(r_match_limit));

    // Loads only happen in idle and queries only read below the fill count,
    // so a query's read never meets a write to the same entry.
    always_ff @(posedge i_clk) begin
        if (load_we) begin
            desc_mem[r_count[IDX_W-1:0]] <= desc_in;
            pt_mem[r_count[IDX_W-1:0]]   <= {i_norm_y_bits, i_norm_x_bits,
                                             i_pixel_y_bits, i_pixel_x_bits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_issue) begin
            r_rd_data <= desc_mem[r_rd_addr[IDX_W-1:0]];
        end
    end

    // Winner index is final once the scan pipe drains; read its points.
    always_ff @(posedge i_clk) begin
        r_pt_rd <= pt_mem[r_best_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_count          <= '0;
            r_v1             <= 1'b0;
            r_v2             <= 1'b0;
            r_out_valid      <= 1'b0;
            r_match_limit    <= bhnm_pkg::MATCH_LIMIT_RST;
            r_search_ceiling <= bhnm_pkg::SEARCH_CEILING_RST;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    bhnm_pkg::CFG_MATCH_LIMIT:    r_match_limit    <= i_cfg_data;
                    bhnm_pkg::CFG_SEARCH_CEILING: r_search_ceiling <= i_cfg_data;
                    default: ;
                endcase
            end

            r_v1 <= scan_issue;
            r_v2 <= r_v1;

            if (res_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        unique case (i_command)
                            bhnm_pkg::CMD_LOAD: begin
                                if (!full) begin
                                    r_count <= r_count + 1'b1;
                                end
                                r_state <= S_DONE;
                            end
                            bhnm_pkg::CMD_CLEAR: begin
                                r_count <= '0;
                                r_state <= S_DONE;
                            end
                            bhnm_pkg::CMD_QUERY: begin
                                r_state <= S_SCAN;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (scan_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Scan pipe: read -> popcount -> compare.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_query    <= desc_in;
            r_best     <= DIST_W'(r_search_ceiling);
            r_best_idx <= '0;
            r_have     <= 1'b0;
            r_rd_addr  <= '0;
            r_is_query <= (i_command == bhnm_pkg::CMD_QUERY);
            r_drop     <= (i_command == bhnm_pkg::CMD_LOAD) && full;
        end else begin
            if (scan_issue) begin
                r_rd_addr <= r_rd_addr + 1'b1;
            end
            if (better) begin
                r_best     <= DIST_W'(dist_sum);
                r_best_idx <= r_idx2;
                r_have     <= 1'b1;
            end
        end
        r_idx1 <= r_rd_addr[IDX_W-1:0];
        r_idx2 <= r_idx1;
        for (int w = 0; w < DESC_WORDS; w++) begin
            r_pc[w] <= bhnm_pkg::f_popcount64(r_query[w] ^ r_rd_data[w]);
        end
    end

    // Output register; holds while stalled.
    always_ff @(posedge i_clk) begin
        if (res_move) begin
            r_found         <= hit;
            r_best_index    <= hit ? bhnm_pkg::OUT_IDX_W'(r_best_idx) : '0;
            r_best_distance <= hit ? bhnm_pkg::OUT_DST_W'(r_best) : '0;
            r_match_pts     <= hit ? r_pt_rd : '0;
            r_status        <= r_drop;
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_out_valid     = r_out_valid;
    assign o_found         = r_found;
    assign o_best_index    = r_best_index;
    assign o_best_distance = r_best_distance;
    assign o_match_pixel_x = r_match_pts[0*PW +: PW];
    assign o_match_pixel_y = r_match_pts[1*PW +: PW];
    assign o_match_norm_x  = r_match_pts[2*PW +: PW];
    assign o_match_norm_y  = r_match_pts[3*PW +: PW];
    assign o_status        = r_status;

endmodule

// ===== src/bhnm_checker.sv =====
module bhnm_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             o_in_stall,
    input  logic                             o_out_valid,
    input  logic                             i_out_stall,
    input  logic                             o_found,
    input  logic [bhnm_pkg::OUT_IDX_W-1:0]   o_best_index,
    input  logic [bhnm_pkg::OUT_DST_W-1:0]   o_best_distance,
    input  logic [bhnm_pkg::PT_W-1:0]        o_match_pixel_x,
    input  logic [bhnm_pkg::PT_W-1:0]        o_match_pixel_y,
    input  logic [bhnm_pkg::PT_W-1:0]        o_match_norm_x,
    input  logic [bhnm_pkg::PT_W-1:0]        o_match_norm_y,
    input  logic                             o_status
);

    // Reset empties the result register and opens the command channel.
    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("state after reset not clean");

    // Every accepted item raises input stall, so no two items go back to back.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("item accepted back to back");

    // A stalled result holds (valid, found, index, distance, pixel x and status).
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_found)
            && $stable(o_best_index) && $stable(o_best_distance)
            && $stable(o_match_pixel_x) && $stable(o_status))
        else $error("stalled result changed");

    // No match means an all-zero payload apart from status.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_best_index == '0 && o_best_distance == '0
            && o_match_pixel_x == '0 && o_match_pixel_y == '0
            && o_match_norm_x == '0 && o_match_norm_y == '0)
        else $error("miss result carries data");

    // A dropped load never reports a match.
    a_found_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_found && o_status))
        else $error("found and status both set");

endmodule

bind brief_hamming_nearest_match bhnm_checker u_bhnm_checker (.*);

// ===== dv/tb_top.sv =====
module tb_top;

    // Command code that the block must ignore (no name in the package).
    localparam logic [bhnm_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    // The slowest legal gap between two accepted items is a full-store query
    // plus a long receiver stall; this is many times that.
    localparam int WATCHDOG_CYCLES = 20000;
    localparam int MAX_MISMATCH_PRINTS = 10;

    // One result item, in the block's own widths.
    // pts: [0] pixel x, [1] pixel y, [2] normalized x, [3] normalized y.
    typedef struct packed {
        logic                                 found;
        logic [bhnm_pkg::OUT_IDX_W-1:0]       idx;
        logic [bhnm_pkg::OUT_DST_W-1:0]       distance;
        logic [3:0][bhnm_pkg::PT_W-1:0]       pts;
        logic                                 status;
    } t_match_result;

    logic                             clk;
    logic                             rst_n;

    logic                             in_valid;
    logic                             in_stall;
    logic [bhnm_pkg::CMD_W-1:0]       in_command;
    logic [255:0]                     in_desc;
    logic [3:0][bhnm_pkg::PT_W-1:0]   in_pts;

    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic                             out_found;
    logic [bhnm_pkg::OUT_IDX_W-1:0]   out_best_index;
    logic [bhnm_pkg::OUT_DST_W-1:0]   out_best_distance;
    logic [bhnm_pkg::PT_W-1:0]        out_pixel_x;
    logic [bhnm_pkg::PT_W-1:0]        out_pixel_y;
    logic [bhnm_pkg::PT_W-1:0]        out_norm_x;
    logic [bhnm_pkg::PT_W-1:0]        out_norm_y;
    logic                             out_status;

    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [bhnm_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [bhnm_pkg::CFG_W-1:0]       cfg_data;

    // When set, neither side inserts idle cycles.
    bit steady = 1'b0;

    // Shadow of the block: reference entries, fill count and registers.
    logic [255:0]                     model_desc_store [bhnm_pkg::MAX_ENTRIES];
    logic [3:0][bhnm_pkg::PT_W-1:0]   model_point_store [bhnm_pkg::MAX_ENTRIES];
    int unsigned                      model_entry_count;
    logic [bhnm_pkg::CFG_W-1:0]       model_match_limit;
    logic [bhnm_pkg::CFG_W-1:0]       model_search_ceiling;

    // Results still owed by the block, oldest first.
    t_match_result          pending_matches [$];

    int unsigned            mismatch_count = 0;
    int unsigned            quiet_cycles = 0;
    t_match_result          got_result;
    t_match_result          want_result;

    brief_hamming_nearest_match dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_command       (in_command),
        .i_desc_word0    (in_desc[63:0]),
        .i_desc_word1    (in_desc[127:64]),
        .i_desc_word2    (in_desc[191:128]),
        .i_desc_word3    (in_desc[255:192]),
        .i_pixel_x_bits  (in_pts[0]),
        .i_pixel_y_bits  (in_pts[1]),
        .i_norm_x_bits   (in_pts[2]),
        .i_norm_y_bits   (in_pts[3]),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_found         (out_found),
        .o_best_index    (out_best_index),
        .o_best_distance (out_best_distance),
        .o_match_pixel_x (out_pixel_x),
        .o_match_pixel_y (out_pixel_y),
        .o_match_norm_x  (out_norm_x),
        .o_match_norm_y  (out_norm_y),
        .o_status        (out_status),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor: applies one command to the shadow store and returns the
    // result item the block owes for it.
    // ------------------------------------------------------------------
    function automatic t_match_result nearest_match_predict(
        input logic [bhnm_pkg::CMD_W-1:0]     cmd,
        input logic [255:0]                   desc,
        input logic [3:0][bhnm_pkg::PT_W-1:0] pts
    );
        t_match_result r;
        int unsigned   best;
        int unsigned   best_i;
        int unsigned   d;
        bit            have;
        r = '0;
        case (cmd)
            bhnm_pkg::CMD_LOAD: begin
                if (model_entry_count < bhnm_pkg::MAX_ENTRIES) begin
                    model_desc_store[model_entry_count]  = desc;
                    model_point_store[model_entry_count] = pts;
                    model_entry_count++;
                end else begin
                    r.status = 1'b1;   // full store: entry dropped
                end
            end
            bhnm_pkg::CMD_CLEAR: begin
                model_entry_count = 0;
            end
            bhnm_pkg::CMD_QUERY: begin
                // Scan in index order; strict compare keeps the earliest on ties.
                best   = 32'(model_search_ceiling);
                best_i = 0;
                have   = 1'b0;
                for (int i = 0; i < model_entry_count; i++) begin
                    d = $countones(desc ^ model_desc_store[i]);
                    if (d < best) begin
                        best   = d;
                        best_i = i;
                        have   = 1'b1;
                    end
                end
                if (have && best < 32'(model_match_limit)) begin
                    r.found    = 1'b1;
                    r.idx      = best_i[bhnm_pkg::OUT_IDX_W-1:0];
                    r.distance = best[bhnm_pkg::OUT_DST_W-1:0];
                    r.pts      = model_point_store[best_i];
                end
            end
            default: ;         // unused code: no state change, all-zero result
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [255:0] rand_desc();
        logic [255:0] v;
        for (int k = 0; k < 8; k++) v[32*k +: 32] = $urandom;
        return v;
    endfunction

    function automatic logic [3:0][bhnm_pkg::PT_W-1:0] rand_pts();
        logic [3:0][bhnm_pkg::PT_W-1:0] p;
        for (int k = 0; k < 4; k++) p[k] = $urandom;
        return p;
    endfunction

    // Low n bits set: Hamming distance n from the all-zero descriptor.
    function automatic logic [255:0] low_ones(input int n);
        return {256{1'b1}} >> (256 - n);
    endfunction

    // Flip k distinct bits, so the result lies exactly k away from base.
    function automatic logic [255:0] flip_bits(input logic [255:0] base, input int k);
        logic [255:0] v;
        logic [255:0] mask;
        int           pos;
        v    = base;
        mask = '0;
        while ($countones(mask) < k) begin
            pos = $urandom_range(255);
            mask[pos] = 1'b1;
        end
        return v ^ mask;
    endfunction

    // Sends one item. Called and returns at a falling edge; valid stays
    // high on return so back-to-back items need no extra cycle.
    task automatic send_cmd(
        input logic [bhnm_pkg::CMD_W-1:0]     cmd,
        input logic [255:0]                   desc,
        input logic [3:0][bhnm_pkg::PT_W-1:0] pts
    );
        int gap;
        if (!steady && $urandom_range(99) < 23) begin
            gap = $urandom_range(1, 5);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_command = cmd;
        in_desc    = desc;
        in_pts     = pts;
        in_valid   = 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pending_matches.insert(pending_matches.size(),
                               nearest_match_predict(cmd, desc, pts));
        @(negedge clk);
    endtask

    // Holds the sender until every owed result has come back.
    task automatic wait_idle();
        in_valid = 1'b0;
        while (pending_matches.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    // Register write, only with the block idle.
    task automatic write_reg(input logic [bhnm_pkg::CFG_IDX_W-1:0] idx,
                             input int unsigned value);
        wait_idle();
        repeat (3) @(negedge clk);
        cfg_index = idx;
        cfg_data  = value[bhnm_pkg::CFG_W-1:0];
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == bhnm_pkg::CFG_MATCH_LIMIT)
            model_match_limit = value[bhnm_pkg::CFG_W-1:0];
        if (idx == bhnm_pkg::CFG_SEARCH_CEILING)
            model_search_ceiling = value[bhnm_pkg::CFG_W-1:0];
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_limits(input int unsigned limit, input int unsigned ceiling);
        write_reg(bhnm_pkg::CFG_MATCH_LIMIT, limit);
        write_reg(bhnm_pkg::CFG_SEARCH_CEILING, ceiling);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset register values; tie-breaking, the match-limit and ceiling
    // boundaries, empty store, the unused code and clear.
    task automatic test_directed();
        logic [255:0] d;
        send_cmd(bhnm_pkg::CMD_QUERY, '0, rand_pts());                // empty store
        send_cmd(bhnm_pkg::CMD_LOAD, '0, {4{32'hFFFF_FFFF}});         // entry 0
        send_cmd(bhnm_pkg::CMD_LOAD, {256{1'b1}}, '0);                // entry 1
        send_cmd(bhnm_pkg::CMD_LOAD, '0, rand_pts());                 // entry 2, twin of 0
        send_cmd(bhnm_pkg::CMD_QUERY, '0, rand_pts());                // tie: entry 0 wins
        send_cmd(bhnm_pkg::CMD_QUERY, {256{1'b1}}, '0);
        send_cmd(bhnm_pkg::CMD_QUERY, low_ones(79), '0);              // just under limit
        send_cmd(bhnm_pkg::CMD_QUERY, low_ones(80), '0);              // at limit: no match
        send_cmd(bhnm_pkg::CMD_QUERY, low_ones(127), '0);             // candidate, over limit
        send_cmd(bhnm_pkg::CMD_QUERY, low_ones(128), '0);             // at ceiling
        send_cmd(CMD_UNUSED, {256{1'b1}}, {4{32'hFFFF_FFFF}});
        send_cmd(bhnm_pkg::CMD_QUERY, '0, '0);                        // store untouched
        send_cmd(bhnm_pkg::CMD_CLEAR, rand_desc(), rand_pts());
        send_cmd(bhnm_pkg::CMD_QUERY, '0, '0);                        // empty again
        d = rand_desc();
        send_cmd(bhnm_pkg::CMD_LOAD, d, rand_pts());
        send_cmd(bhnm_pkg::CMD_QUERY, d, '0);
        send_cmd(bhnm_pkg::CMD_QUERY, ~d, '0);                        // distance 256
    endtask

    // Register extremes: full-range distances and registers at zero.
    task automatic test_config_extremes();
        set_limits(257, 257);
        send_cmd(bhnm_pkg::CMD_CLEAR, '0, '0);
        send_cmd(bhnm_pkg::CMD_LOAD, '0, rand_pts());
        send_cmd(bhnm_pkg::CMD_QUERY, {256{1'b1}}, '0);               // 256 matches
        write_reg(bhnm_pkg::CFG_SEARCH_CEILING, 256);
        send_cmd(bhnm_pkg::CMD_QUERY, {256{1'b1}}, '0);               // 256 not below ceiling
        send_cmd(bhnm_pkg::CMD_QUERY, low_ones(255), '0);
        write_reg(bhnm_pkg::CFG_SEARCH_CEILING, 0);
        send_cmd(bhnm_pkg::CMD_QUERY, '0, '0);                        // nothing is a candidate
        set_limits(0, 257);
        send_cmd(bhnm_pkg::CMD_QUERY, '0, '0);                        // nothing matches
        write_reg(bhnm_pkg::CFG_MATCH_LIMIT, 1);
        send_cmd(bhnm_pkg::CMD_QUERY, '0, '0);
    endtask

    // Fill all entries back to back, then overflow, search the far end, the first entry and the middle, and clear.
    task automatic test_store_full();
        set_limits(int'(bhnm_pkg::MATCH_LIMIT_RST), int'(bhnm_pkg::SEARCH_CEILING_RST));
        steady = 1'b1;
        send_cmd(bhnm_pkg::CMD_CLEAR, '0, '0);
        for (int i = 0; i < bhnm_pkg::MAX_ENTRIES; i++)
            send_cmd(bhnm_pkg::CMD_LOAD, rand_desc(), rand_pts());
        send_cmd(bhnm_pkg::CMD_LOAD, rand_desc(), rand_pts());        // dropped
        send_cmd(bhnm_pkg::CMD_LOAD, {256{1'b1}}, {4{32'hFFFF_FFFF}});// dropped
        send_cmd(bhnm_pkg::CMD_QUERY,
                 flip_bits(model_desc_store[bhnm_pkg::MAX_ENTRIES-1], 3), '0);
        send_cmd(bhnm_pkg::CMD_QUERY, model_desc_store[0], '0);
        steady = 1'b0;
        send_cmd(bhnm_pkg::CMD_QUERY,
                 flip_bits(model_desc_store[bhnm_pkg::MAX_ENTRIES/2], 40), '0);
        send_cmd(bhnm_pkg::CMD_CLEAR, '0, '0);
        send_cmd(bhnm_pkg::CMD_LOAD, '0, '0);                         // room again
    endtask

    // The sender waits for every result before each query.
    task automatic test_paced_queries();
        send_cmd(bhnm_pkg::CMD_CLEAR, '0, '0);
        repeat (8) send_cmd(bhnm_pkg::CMD_LOAD, rand_desc(), rand_pts());
        repeat (10) begin
            wait_idle();
            send_cmd(bhnm_pkg::CMD_QUERY,
                     flip_bits(model_desc_store[$urandom_range(7)], $urandom_range(90)),
                     rand_pts());
        end
    endtask

    // One random command, mostly loads and near-miss queries so that the
    // search finds real winners; a few clears, blind queries and code 3.
    task automatic send_random_cmd();
        int           roll;
        int           k;
        logic [255:0] base;
        roll = $urandom_range(99);
        if (roll < 3 || (model_entry_count >= 48 && roll < 15)) begin
            send_cmd(bhnm_pkg::CMD_CLEAR, rand_desc(), rand_pts());
        end else if (roll < 6) begin
            send_cmd(CMD_UNUSED, rand_desc(), rand_pts());
        end else if (roll < 40) begin
            send_cmd(bhnm_pkg::CMD_LOAD, rand_desc(), rand_pts());
        end else if (roll < 46 || model_entry_count == 0) begin
            send_cmd(bhnm_pkg::CMD_QUERY, rand_desc(), rand_pts());
        end else begin
            base = model_desc_store[$urandom_range(model_entry_count - 1)];
            case ($urandom_range(3))
                0:       k = $urandom_range(4);
                1:       k = $urandom_range(70, 90);    // around the match limit
                2:       k = $urandom_range(115, 140);  // around the ceiling
                default: k = $urandom_range(256);
            endcase
            send_cmd(bhnm_pkg::CMD_QUERY, flip_bits(base, k), rand_pts());
        end
    endtask

    // Short random traffic in phases, each under its own register setting.
    task automatic test_random();
        int unsigned limits [6]   = '{80, 257, 0, 150, 256, 0};
        int unsigned ceilings [6] = '{128, 257, 200, 60, 256, 0};
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5) set_limits($urandom_range(257), $urandom_range(257));
            else         set_limits(limits[ph], ceilings[ph]);
            steady = (ph == 2);
            repeat (4) send_random_cmd();
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall, changed at the falling edge.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        out_stall <= !steady && ($urandom_range(99) < 23);
    end

    // Result check at the rising edge against the oldest owed item.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            got_result.found    = out_found;
            got_result.idx      = out_best_index;
            got_result.distance = out_best_distance;
            got_result.pts[0]   = out_pixel_x;
            got_result.pts[1]   = out_pixel_y;
            got_result.pts[2]   = out_norm_x;
            got_result.pts[3]   = out_norm_y;
            got_result.status   = out_status;
            if (pending_matches.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_MISMATCH_PRINTS)
                    $display("unexpected result: found=%0b idx=%0d dist=%0d pts=%h status=%0b",
                             got_result.found, got_result.idx, got_result.distance,
                             got_result.pts, got_result.status);
            end else begin
                want_result = pending_matches.pop_front();
                if (got_result !== want_result) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_MISMATCH_PRINTS) begin
                        $display("result mismatch:");
                        $display("  want found=%0b idx=%0d dist=%0d pts=%h status=%0b",
                                 want_result.found, want_result.idx, want_result.distance,
                                 want_result.pts, want_result.status);
                        $display("  got  found=%0b idx=%0d dist=%0d pts=%h status=%0b",
                                 got_result.found, got_result.idx, got_result.distance,
                                 got_result.pts, got_result.status);
                    end
                end
            end
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("timeout with %0d results outstanding", pending_matches.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_command = bhnm_pkg::CMD_LOAD;
        in_desc    = '0;
        in_pts     = '0;
        cfg_valid  = 1'b0;
        cfg_index  = bhnm_pkg::CFG_MATCH_LIMIT;
        cfg_data   = '0;
        model_entry_count    = 0;
        model_match_limit    = bhnm_pkg::MATCH_LIMIT_RST;
        model_search_ceiling = bhnm_pkg::SEARCH_CEILING_RST;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_config_extremes();
        test_store_full();
        test_paced_queries();
        test_random();

        wait_idle();
        repeat (20) @(posedge clk);   // catch any stray result
        if (mismatch_count == 0 && pending_matches.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
